/* sv/spkcbc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and rotate helpers for the Speck128/256 CBC decryptor.
// No dependencies; every module of the block except the port-level checker imports this package.
package spkcbc_pkg;

    localparam int SPK_ROUNDS = 34;
    localparam int RK_AW      = 6;
    localparam int ROT_ALPHA  = 8;
    localparam int ROT_BETA   = 3;

    typedef logic [63:0]      word_t;
    typedef logic [RK_AW-1:0] rk_addr_t;

    localparam rk_addr_t RK_FIRST = rk_addr_t'(0);
    localparam rk_addr_t RK_LAST  = rk_addr_t'(SPK_ROUNDS - 1);

    // Configuration register indexes
    typedef logic [2:0] cfg_idx_t;
    localparam cfg_idx_t CFG_KEY0 = 3'd0;
    localparam cfg_idx_t CFG_KEY1 = 3'd1;
    localparam cfg_idx_t CFG_KEY2 = 3'd2;
    localparam cfg_idx_t CFG_KEY3 = 3'd3;
    localparam cfg_idx_t CFG_IV0  = 3'd4;
    localparam cfg_idx_t CFG_IV1  = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEYS,
        ST_LOAD,
        ST_ROUND,
        ST_FINISH
    } state_t;

    // Sequencer controls toward the datapath
    typedef struct packed {
        logic     busy;
        logic     ks_start;
        rk_addr_t rd_addr;
        logic     rnd_en;
        logic     fin;
    } ctl_t;

    // Key schedule write request into the round key memory
    typedef struct packed {
        logic     en;
        rk_addr_t addr;
        word_t    data;
        logic     done;
    } ks_wr_t;

    function automatic word_t rotl_alpha(input word_t v);
        return (v << ROT_ALPHA) | (v >> (64 - ROT_ALPHA));
    endfunction

    function automatic word_t rotr_alpha(input word_t v);
        return (v >> ROT_ALPHA) | (v << (64 - ROT_ALPHA));
    endfunction

    function automatic word_t rotl_beta(input word_t v);
        return (v << ROT_BETA) | (v >> (64 - ROT_BETA));
    endfunction

    function automatic word_t rotr_beta(input word_t v);
        return (v >> ROT_BETA) | (v << (64 - ROT_BETA));
    endfunction

endpackage

/* sv/spkcbc_rnd.sv */
`timescale 1ns / 1ps
// Speck128 inverse round: one subtract, xors and fixed rotates.
// Depends on spkcbc_pkg.
module spkcbc_rnd
    import spkcbc_pkg::*;
(
    input  word_t x,
    input  word_t y,
    input  word_t rk,
    output word_t x_nx,
    output word_t y_nx
);

    always_comb
    begin
        y_nx = rotr_beta(y ^ x);
        x_nx = rotl_alpha((x ^ rk) - y_nx);
    end

endmodule

/* sv/spkcbc_ksched.sv */
`timescale 1ns / 1ps
// Iterative Speck128/256 key schedule: one round key per cycle until all 34 are written.
// Depends on spkcbc_pkg; writes go to the round key memory in the top level.
module spkcbc_ksched
    import spkcbc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  word_t  key0,
    input  word_t  key1,
    input  word_t  key2,
    input  word_t  key3,
    output ks_wr_t wr
);

    logic     busy_reg, busy_next;
    rk_addr_t n_reg, n_next;
    word_t    a_reg, a_next;
    word_t    l0_reg, l1_reg, l2_reg;
    word_t    l0_next, l1_next, l2_next;
    word_t    l_new;

    // l0 is always the word used at this step; rotate the three after use
    assign l_new = (rotr_alpha(l0_reg) + a_reg) ^ word_t'(n_reg);

    always_comb
    begin
        busy_next = busy_reg;
        n_next    = n_reg;
        a_next    = a_reg;
        l0_next   = l0_reg;
        l1_next   = l1_reg;
        l2_next   = l2_reg;
        if (start)
        begin
            busy_next = 1'b1;
            n_next    = RK_FIRST;
            a_next    = key0;
            l0_next   = key1;
            l1_next   = key2;
            l2_next   = key3;
        end
        else if (busy_reg)
        begin
            if (n_reg == RK_LAST)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                n_next  = n_reg + rk_addr_t'(1);
                a_next  = rotl_beta(a_reg) ^ l_new;
                l0_next = l1_reg;
                l1_next = l2_reg;
                l2_next = l_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            n_reg    <= RK_FIRST;
        end
        else
        begin
            busy_reg <= busy_next;
            n_reg    <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        l0_reg <= l0_next;
        l1_reg <= l1_next;
        l2_reg <= l2_next;
    end

    always_comb
    begin
        wr.en   = busy_reg;
        wr.addr = n_reg;
        wr.data = a_reg;
        wr.done = busy_reg && (n_reg == RK_LAST);
    end

endmodule

/* sv/spkcbc_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer: key expansion, round key fetch, 34 inverse rounds, result hand-off.
// Depends on spkcbc_pkg.
module spkcbc_ctrl
    import spkcbc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic first,
    input  logic ks_done,
    input  logic out_free,
    output ctl_t ctl
);

    state_t   state_reg, state_next;
    rk_addr_t cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = first ? ST_KEYS : ST_LOAD;
                end
            end
            ST_KEYS:
            begin
                if (ks_done)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (cnt_reg == RK_FIRST)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        case (state_reg)
            ST_LOAD:  cnt_next = RK_LAST;
            ST_ROUND: cnt_next = cnt_reg - rk_addr_t'(1);
            default:  cnt_next = cnt_reg;
        endcase
    end

    always_comb
    begin
        ctl.busy     = 1'b1;
        ctl.ks_start = 1'b0;
        ctl.rd_addr  = RK_FIRST;
        ctl.rnd_en   = 1'b0;
        ctl.fin      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                ctl.busy     = 1'b0;
                ctl.ks_start = in_valid && first;
            end
            ST_LOAD:
            begin
                ctl.rd_addr = RK_LAST;
            end
            ST_ROUND:
            begin
                ctl.rnd_en  = 1'b1;
                // prefetch the key for the following round
                ctl.rd_addr = (cnt_reg == RK_FIRST) ? RK_FIRST : cnt_reg - rk_addr_t'(1);
            end
            ST_FINISH:
            begin
                ctl.fin = out_free;
            end
            default:
            begin
                ctl.busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= RK_FIRST;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* sv/speck128_256_cbc_decrypt.sv */
`timescale 1ns / 1ps
// Speck128/256 CBC decryptor top level: config registers, round key memory,
// chain and output registers. Depends on spkcbc_pkg, spkcbc_rnd, spkcbc_ksched, spkcbc_ctrl.
//
// One 128-bit ciphertext block is taken per request (ct_word0 is the y half,
// ct_word1 the x half) and one plaintext block comes back per request. The
// block works on one request at a time: in_stall is high from the cycle after
// a request is taken until the result has moved into the output register.
// For a plain block, the steps from accept to the next possible accept are:
// fetch the last round key from the 34-entry round key memory, run the 34
// rounds through the single shared inverse-round unit (one round per cycle),
// xor with the chain and load the output register, and return to idle, where
// the next request is taken. A block with first_block set first passes
// through the key step, in which the iterative key schedule writes one round
// key per cycle, and the chain reloads from the IV registers when the block
// is taken. The output register holds a finished result while out_stall
// is high, and a new request is accepted meanwhile; the following result
// waits in the finish step until the register frees up. Key and IV register
// writes take effect at the next request with first_block set. Decrypting
// before any first_block request since reset reads unwritten round keys and
// gives undefined plaintext.
module speck128_256_cbc_decrypt
    import spkcbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] ct_word0,
    input  logic [63:0] ct_word1,
    input  logic        first_block,
    input  logic        last_block,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] pt_word0,
    output logic [63:0] pt_word1,
    output logic        last_out
);

    // Configuration registers
    word_t key0_reg, key1_reg, key2_reg, key3_reg;
    word_t iv0_reg, iv1_reg;

    // Working block and saved request
    word_t x_reg, y_reg;
    word_t ct0_reg, ct1_reg;
    logic  last_reg;
    word_t x_rnd, y_rnd;

    // CBC chain
    word_t chain_lo_reg, chain_hi_reg;

    // Output register
    logic  out_valid_reg;
    word_t pt0_reg, pt1_reg;
    logic  last_out_reg;

    // Round key memory
    word_t  rk_mem [SPK_ROUNDS];
    word_t  rk_q;

    ctl_t   ctl;
    ks_wr_t ks_wr;
    logic   in_acc;
    logic   out_free;

    assign in_stall = ctl.busy;
    assign in_acc   = in_valid && !ctl.busy;
    assign out_free = !out_valid_reg || !out_stall;

    // Ignore writes to unused indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg <= '0;
            key1_reg <= '0;
            key2_reg <= '0;
            key3_reg <= '0;
            iv0_reg  <= '0;
            iv1_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_KEY0: key0_reg <= cfg_data;
                CFG_KEY1: key1_reg <= cfg_data;
                CFG_KEY2: key2_reg <= cfg_data;
                CFG_KEY3: key3_reg <= cfg_data;
                CFG_IV0:  iv0_reg  <= cfg_data;
                CFG_IV1:  iv1_reg  <= cfg_data;
                default:  ;
            endcase
        end
    end

    spkcbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .first    (first_block),
        .ks_done  (ks_wr.done),
        .out_free (out_free),
        .ctl      (ctl)
    );

    spkcbc_ksched u_ksched (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.ks_start),
        .key0  (key0_reg),
        .key1  (key1_reg),
        .key2  (key2_reg),
        .key3  (key3_reg),
        .wr    (ks_wr)
    );

    // Write from the key schedule, registered read for the rounds
    always_ff @(posedge clk)
    begin
        if (ks_wr.en)
        begin
            rk_mem[ks_wr.addr] <= ks_wr.data;
        end
        rk_q <= rk_mem[ctl.rd_addr];
    end

    spkcbc_rnd u_rnd (
        .x    (x_reg),
        .y    (y_reg),
        .rk   (rk_q),
        .x_nx (x_rnd),
        .y_nx (y_rnd)
    );

    // Capture the request, then advance one round per cycle
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            y_reg    <= ct_word0;
            x_reg    <= ct_word1;
            ct0_reg  <= ct_word0;
            ct1_reg  <= ct_word1;
            last_reg <= last_block;
        end
        else if (ctl.rnd_en)
        begin
            y_reg <= y_rnd;
            x_reg <= x_rnd;
        end
    end

    // Reload the chain from the IV on a first block; take the ciphertext after each result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_lo_reg <= '0;
            chain_hi_reg <= '0;
        end
        else if (in_acc && first_block)
        begin
            chain_lo_reg <= iv0_reg;
            chain_hi_reg <= iv1_reg;
        end
        else if (ctl.fin)
        begin
            chain_lo_reg <= ct0_reg;
            chain_hi_reg <= ct1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.fin)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.fin)
        begin
            pt0_reg      <= y_reg ^ chain_lo_reg;
            pt1_reg      <= x_reg ^ chain_hi_reg;
            last_out_reg <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign pt_word0  = pt0_reg;
    assign pt_word1  = pt1_reg;
    assign last_out  = last_out_reg;

endmodule

/* sv/spkcbc_chk.sv */
`timescale 1ns / 1ps
// Port-level checker for the Speck128/256 CBC decryptor, bound to the top level.
// Depends on the top level's ports only.
module spkcbc_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] pt_word0,
    input logic [63:0] pt_word1,
    input logic        last_out
);

    // Block goes busy right after taking a request
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("in_stall low the cycle after a request was taken");

    // No result appears the cycle after a request when none was pending
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result appeared one cycle after request");

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(pt_word0) && $stable(pt_word1) && $stable(last_out))
    else $error("stalled result changed");

endmodule

bind speck128_256_cbc_decrypt spkcbc_chk u_spkcbc_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pt_word0  (pt_word0),
    .pt_word1  (pt_word1),
    .last_out  (last_out)
);
